// ===== hdl/bpf_pkg.sv =====
// Shared types and constants for the Bezier path flattener.
// Used by bpf_mul and bezier_path_flattener_top; no dependencies.
`timescale 1ns / 1ps

package bpf_pkg;

  localparam int COORD_W       = 32;
  localparam int PPU_W         = 16;
  localparam logic [PPU_W-1:0] PPU_RESET = 16'd256;
  // Curve coefficients: up to three coordinate differences summed, plus margin
  localparam int COEF_W        = 38;
  // Shared multiplier signed operand width
  localparam int MUL_AW        = 40;
  // Manhattan length: six 33-bit magnitudes
  localparam int LEN_W         = 36;
  // Coordinate frac + scale frac + divide by 8
  localparam int LEN_SHIFT     = 27;
  localparam int MIN_PTS       = 3;

  localparam int MAX_STEPS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  // Segment kinds
  localparam logic [1:0] KIND_MOVE  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_QUAD  = 2'd2;
  localparam logic [1:0] KIND_CUBIC = 2'd3;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] ctrl1_x;
    logic signed [COORD_W-1:0] ctrl1_y;
    logic signed [COORD_W-1:0] ctrl2_x;
    logic signed [COORD_W-1:0] ctrl2_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_of_run;
  } out_t;

endpackage

// ===== hdl/bpf_mul.sv =====
// Shared multiplier: signed operand times unsigned operand, registered product.
// Depends on bpf_pkg.
`timescale 1ns / 1ps

module bpf_mul #(
  parameter int BW = bpf_pkg::PPU_W
) (
  input  logic                               clk_i,
  input  logic signed [bpf_pkg::MUL_AW-1:0]  a_i,
  input  logic        [BW-1:0]               b_i,
  output logic signed [bpf_pkg::MUL_AW+BW:0] p_o
);
  import bpf_pkg::*;

  logic signed [MUL_AW+BW:0] p_q;

  // registered product
  always_ff @(posedge clk_i) begin
    p_q <= (MUL_AW+BW+1)'(a_i) * $signed({1'b0, b_i});
  end

  assign p_o = p_q;

endmodule

// ===== hdl/bezier_path_flattener_top.sv =====
// Bezier path flattener top level: sequencer, divider and datapath around bpf_mul.
// Depends on bpf_pkg and bpf_mul.
`timescale 1ns / 1ps
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid_i, in_stall_o, in_data_i   | in
//  output  | out_valid_o, out_stall_i, out_data_o| out
//  config  | cfg_we_i, cfg_wdata_i               | in
//
// Start and line requests go straight to the emit step. A curve first sums its Manhattan
// length, scales and clamps the step count and forms the coefficients, then per point
// runs the restoring divider (FRAC_BITS + clog2(MAX_STEPS+2) quotient bits), the nine
// multiplier steps, the final shift and the emit.
// Reset clears the sequencer, current point and scale register (1.0).
// Output stalls hold the sequencer at the emit step; a new request is taken
// while the last point of the previous one waits in the output register.

module bezier_path_flattener_top #(
  parameter int MAX_STEPS = bpf_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS = bpf_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bpf_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bpf_pkg::out_t               out_data_o,
  input  logic                        cfg_we_i,
  input  logic [bpf_pkg::PPU_W-1:0]   cfg_wdata_i
);
  import bpf_pkg::*;

  localparam int NW  = $clog2(MAX_STEPS + 2);
  localparam int BW  = (FRAC_BITS > PPU_W) ? FRAC_BITS : PPU_W;
  localparam int PW  = MUL_AW + BW + 1;
  localparam int DW  = NW + FRAC_BITS;
  localparam int DCW = $clog2(DW + 1);
  localparam int ACW = PW + 2;
  localparam int RW  = PW - LEN_SHIFT;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LEN  = 4'd1;
  localparam logic [3:0] S_SCL  = 4'd2;
  localparam logic [3:0] S_SCLW = 4'd3;
  localparam logic [3:0] S_CO1  = 4'd4;
  localparam logic [3:0] S_CO2  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  function automatic logic [32:0] absdiff(logic signed [COORD_W-1:0] a,
                                          logic signed [COORD_W-1:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(logic signed [ACW-1:0] v);
    if (v[ACW-1:COORD_W-1] == '0 || v[ACW-1:COORD_W-1] == '1) begin
      return v[COORD_W-1:0];
    end
    return v[ACW-1] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

  logic [3:0]                state_q, state_d;
  logic [2:0]                cnt_q, cnt_d;
  logic [3:0]                s_q, s_d;
  logic                      cub_q, cub_d;
  logic signed [COORD_W-1:0] p0x_q, p0x_d, p0y_q, p0y_d;
  logic signed [COORD_W-1:0] p1x_q, p1x_d, p1y_q, p1y_d;
  logic signed [COORD_W-1:0] p2x_q, p2x_d, p2y_q, p2y_d;
  logic signed [COORD_W-1:0] pex_q, pex_d, pey_q, pey_d;
  logic [LEN_W-1:0]          len_q, len_d;
  logic [NW-1:0]             n_q, n_d, i_q, i_d;
  logic [NW-1:0]             rem_q, rem_d;
  logic [DW-1:0]             dq_q, dq_d;
  logic [DCW-1:0]            dc_q, dc_d;
  logic [FRAC_BITS-1:0]      t_q, t_d, t2_q, t2_d, t3_q, t3_d;
  logic signed [COEF_W-1:0]  d1x_q, d1x_d, d2x_q, d2x_d, ex_q, ex_d;
  logic signed [COEF_W-1:0]  d1y_q, d1y_d, d2y_q, d2y_d, ey_q, ey_d;
  logic signed [COEF_W-1:0]  a1x_q, a1x_d, a2x_q, a2x_d, a3x_q, a3x_d;
  logic signed [COEF_W-1:0]  a1y_q, a1y_d, a2y_q, a2y_d, a3y_q, a3y_d;
  logic signed [ACW-1:0]     accx_q, accx_d, accy_q, accy_d;
  logic signed [COORD_W-1:0] px_q, px_d, py_q, py_d;
  logic                      plast_q, plast_d;
  out_t                      out_q, out_d;
  logic                      ovld_q, ovld_d;
  logic [PPU_W-1:0]          ppu_q;
  logic signed [COORD_W-1:0] curx_q, curx_d, cury_q, cury_d;

  logic signed [MUL_AW-1:0]  mul_a;
  logic [BW-1:0]             mul_b;
  logic signed [PW-1:0]      prod;

  // Shared multiplier
  bpf_mul #(.BW(BW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Multiplier operand select; t2 and t3 are bypassed from the product
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_SCL) begin
      mul_a = MUL_AW'(len_q);
      mul_b = BW'(ppu_q);
    end else if (state_q == S_MUL) begin
      case (s_q)
        4'd0: begin mul_a = MUL_AW'(t_q); mul_b = BW'(t_q); end
        4'd1: begin
          mul_a = MUL_AW'(prod[FRAC_BITS +: FRAC_BITS]);
          mul_b = BW'(t_q);
        end
        4'd2: begin mul_a = MUL_AW'(a3x_q); mul_b = BW'(prod[FRAC_BITS +: FRAC_BITS]); end
        4'd3: begin mul_a = MUL_AW'(a2x_q); mul_b = BW'(t2_q); end
        4'd4: begin mul_a = MUL_AW'(a1x_q); mul_b = BW'(t_q); end
        4'd5: begin mul_a = MUL_AW'(a3y_q); mul_b = BW'(t3_q); end
        4'd6: begin mul_a = MUL_AW'(a2y_q); mul_b = BW'(t2_q); end
        4'd7: begin mul_a = MUL_AW'(a1y_q); mul_b = BW'(t_q); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // Sequencer and datapath
  logic [32:0]       term;
  logic [NW:0]       dtrial;
  logic [NW-1:0]     m_div;
  logic [RW-1:0]     raw;
  logic signed [COEF_W-1:0] u_x, u_y;
  logic signed [ACW-1:0]    vx, vy;

  assign m_div = n_q - NW'(1);
  assign raw   = prod[PW-1:LEN_SHIFT];

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; s_d = s_q; cub_d = cub_q;
    p0x_d = p0x_q; p0y_d = p0y_q; p1x_d = p1x_q; p1y_d = p1y_q;
    p2x_d = p2x_q; p2y_d = p2y_q; pex_d = pex_q; pey_d = pey_q;
    len_d = len_q; n_d = n_q; i_d = i_q; rem_d = rem_q; dq_d = dq_q; dc_d = dc_q;
    t_d = t_q; t2_d = t2_q; t3_d = t3_q;
    d1x_d = d1x_q; d2x_d = d2x_q; ex_d = ex_q; d1y_d = d1y_q; d2y_d = d2y_q; ey_d = ey_q;
    a1x_d = a1x_q; a2x_d = a2x_q; a3x_d = a3x_q;
    a1y_d = a1y_q; a2y_d = a2y_q; a3y_d = a3y_q;
    accx_d = accx_q; accy_d = accy_q;
    px_d = px_q; py_d = py_q; plast_d = plast_q;
    out_d = out_q; curx_d = curx_q; cury_d = cury_q;
    ovld_d = ovld_q && out_stall_i;
    term = '0; dtrial = '0; u_x = '0; u_y = '0; vx = '0; vy = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          p0x_d = curx_q; p0y_d = cury_q;
          p1x_d = in_data_i.ctrl1_x; p1y_d = in_data_i.ctrl1_y;
          p2x_d = in_data_i.ctrl2_x; p2y_d = in_data_i.ctrl2_y;
          pex_d = in_data_i.end_x;   pey_d = in_data_i.end_y;
          cub_d = (in_data_i.kind == KIND_CUBIC);
          if (in_data_i.kind == KIND_QUAD || in_data_i.kind == KIND_CUBIC) begin
            len_d = '0; cnt_d = '0; state_d = S_LEN;
          end else begin
            px_d = in_data_i.end_x; py_d = in_data_i.end_y; plast_d = 1'b1;
            state_d = S_EMIT;
          end
        end
      end
      // Manhattan length, one term per cycle
      S_LEN: begin
        case (cnt_q)
          3'd0: term = absdiff(p0x_q, p1x_q);
          3'd1: term = absdiff(p0y_q, p1y_q);
          3'd2: term = absdiff(p1x_q, cub_q ? p2x_q : pex_q);
          3'd3: term = absdiff(p1y_q, cub_q ? p2y_q : pey_q);
          3'd4: term = absdiff(p2x_q, pex_q);
          3'd5: term = absdiff(p2y_q, pey_q);
          default: term = '0;
        endcase
        len_d = len_q + LEN_W'(term);
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == (cub_q ? 3'd5 : 3'd3)) state_d = S_SCL;
      end
      S_SCL: state_d = S_SCLW;
      // Step count clamp
      S_SCLW: begin
        if (raw < RW'(MIN_PTS)) n_d = NW'(MIN_PTS);
        else if (raw > RW'(MAX_STEPS + 1)) n_d = NW'(MAX_STEPS + 1);
        else n_d = NW'(raw);
        state_d = S_CO1;
      end
      S_CO1: begin
        d1x_d = COEF_W'(p1x_q) - COEF_W'(p0x_q);
        d1y_d = COEF_W'(p1y_q) - COEF_W'(p0y_q);
        d2x_d = COEF_W'(cub_q ? p2x_q : pex_q) - COEF_W'(p1x_q);
        d2y_d = COEF_W'(cub_q ? p2y_q : pey_q) - COEF_W'(p1y_q);
        ex_d  = COEF_W'(pex_q) - COEF_W'(p0x_q);
        ey_d  = COEF_W'(pey_q) - COEF_W'(p0y_q);
        state_d = S_CO2;
      end
      // Power-basis coefficients
      S_CO2: begin
        u_x = d2x_q - d1x_q;
        u_y = d2y_q - d1y_q;
        if (cub_q) begin
          a1x_d = d1x_q + (d1x_q <<< 1);  a1y_d = d1y_q + (d1y_q <<< 1);
          a2x_d = u_x + (u_x <<< 1);      a2y_d = u_y + (u_y <<< 1);
          a3x_d = ex_q - d2x_q - (d2x_q <<< 1);
          a3y_d = ey_q - d2y_q - (d2y_q <<< 1);
        end else begin
          a1x_d = d1x_q <<< 1; a1y_d = d1y_q <<< 1;
          a2x_d = u_x;         a2y_d = u_y;
          a3x_d = '0;          a3y_d = '0;
        end
        i_d = NW'(1);
        dq_d = DW'(1) << FRAC_BITS;
        rem_d = '0; dc_d = '0;
        state_d = S_DIV;
      end
      // Restoring divide: t = (i << FRAC_BITS) / (n - 1)
      S_DIV: begin
        dtrial = {rem_q, dq_q[DW-1]};
        if (dtrial >= {1'b0, m_div}) begin
          rem_d = NW'(dtrial - {1'b0, m_div});
          dq_d  = {dq_q[DW-2:0], 1'b1};
        end else begin
          rem_d = NW'(dtrial);
          dq_d  = {dq_q[DW-2:0], 1'b0};
        end
        dc_d = dc_q + DCW'(1);
        if (dc_q == DCW'(DW - 1)) begin
          t_d = dq_d[FRAC_BITS-1:0];
          s_d = '0;
          state_d = S_MUL;
        end
      end
      // Eight products on the shared multiplier, each consumed in the cycle after its operands are selected
      S_MUL: begin
        case (s_q)
          4'd1: t2_d = prod[FRAC_BITS +: FRAC_BITS];
          4'd2: t3_d = prod[FRAC_BITS +: FRAC_BITS];
          4'd3: accx_d = ACW'(prod);
          4'd4, 4'd5: accx_d = accx_q + ACW'(prod);
          4'd6: accy_d = ACW'(prod);
          4'd7, 4'd8: accy_d = accy_q + ACW'(prod);
          default: ;
        endcase
        s_d = s_q + 4'd1;
        if (s_q == 4'd8) state_d = S_FIN;
      end
      // Floor shift, add start point, saturate
      S_FIN: begin
        vx = (accx_q >>> FRAC_BITS) + ACW'(p0x_q);
        vy = (accy_q >>> FRAC_BITS) + ACW'(p0y_q);
        px_d = sat32(vx); py_d = sat32(vy); plast_d = 1'b0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!ovld_q || !out_stall_i) begin
          out_d.point_x = px_q; out_d.point_y = py_q; out_d.last_of_run = plast_q;
          ovld_d = 1'b1;
          if (plast_q) begin
            curx_d = px_q; cury_d = py_q;
            state_d = S_IDLE;
          end else if (i_q == n_q - NW'(2)) begin
            px_d = pex_q; py_d = pey_q; plast_d = 1'b1;
          end else begin
            i_d = i_q + NW'(1);
            dq_d = DW'(i_d) << FRAC_BITS;
            rem_d = '0; dc_d = '0;
            state_d = S_DIV;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
      ppu_q   <= PPU_RESET;
      curx_q  <= '0;
      cury_q  <= '0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      curx_q  <= curx_d;
      cury_q  <= cury_d;
      if (cfg_we_i) ppu_q <= cfg_wdata_i;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d; s_q <= s_d; cub_q <= cub_d;
    p0x_q <= p0x_d; p0y_q <= p0y_d; p1x_q <= p1x_d; p1y_q <= p1y_d;
    p2x_q <= p2x_d; p2y_q <= p2y_d; pex_q <= pex_d; pey_q <= pey_d;
    len_q <= len_d; n_q <= n_d; i_q <= i_d; rem_q <= rem_d; dq_q <= dq_d; dc_q <= dc_d;
    t_q <= t_d; t2_q <= t2_d; t3_q <= t3_d;
    d1x_q <= d1x_d; d2x_q <= d2x_d; ex_q <= ex_d;
    d1y_q <= d1y_d; d2y_q <= d2y_d; ey_q <= ey_d;
    a1x_q <= a1x_d; a2x_q <= a2x_d; a3x_q <= a3x_d;
    a1y_q <= a1y_d; a2y_q <= a2y_d; a3y_q <= a3y_d;
    accx_q <= accx_d; accy_q <= accy_d;
    px_q <= px_d; py_q <= py_d; plast_q <= plast_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ovld_q;
  assign out_data_o  = out_q;

  // Step count stays in range while points are generated
  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (n_q >= NW'(MIN_PTS) && n_q <= NW'(MAX_STEPS + 1)))
    else $error("step count out of range");

  // Interior index stays below the end point
  a_i_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (i_q >= NW'(1) && i_q <= n_q - NW'(2)))
    else $error("point index out of range");

  // An accepted request leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("request accepted but sequencer idle");

  // Returning to idle means the last point was just loaded
  a_last_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && state_d == S_IDLE) |=> (out_valid_o && out_data_o.last_of_run))
    else $error("run ended without last point");

endmodule

// ===== verif/bezier_path_flattener_checker.sv =====
// Checker for the Bezier path flattener: watches the segment, point and scale ports,
// predicts the polyline points of every accepted request and compares them in order.
// Depends on bpf_pkg.
`timescale 1ns / 1ps

module bezier_path_flattener_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  bpf_pkg::in_t              in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  bpf_pkg::out_t             out_data_i,
  input  logic                      cfg_we_i,
  input  logic [bpf_pkg::PPU_W-1:0] cfg_wdata_i,
  output int                        pending_o,
  output int                        fail_count_o,
  output int                        points_o
);
  import bpf_pkg::*;

  localparam int FRAC  = FRAC_BITS_DEF;
  localparam int STEPS = MAX_STEPS_DEF;

  // Shadow copies of the scale register and the current point
  logic [PPU_W-1:0] scale_q;
  longint           pen_x, pen_y;
  out_t             point_queue[$];

  function automatic longint mag(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] curve_coord(longint p0, longint k3, longint k2,
                                              longint k1, longint t, longint t2,
                                              longint t3);
    longint acc;
    acc = k3 * t3 + k2 * t2 + k1 * t;
    return 32'(clip32((acc >>> FRAC) + p0));
  endfunction

  // Push the points a segment request should produce; update the pen position
  function automatic void flatten_segment(in_t req);
    longint x1, y1, x2, y2, xe, ye, len, steps;
    longint ax1, ax2, ax3, ay1, ay2, ay3, t, t2, t3;
    out_t pt;
    x1 = longint'(req.ctrl1_x);
    y1 = longint'(req.ctrl1_y);
    x2 = longint'(req.ctrl2_x);
    y2 = longint'(req.ctrl2_y);
    xe = longint'(req.end_x);
    ye = longint'(req.end_y);
    if (req.kind == KIND_QUAD || req.kind == KIND_CUBIC) begin
      if (req.kind == KIND_QUAD) begin
        len = mag(pen_x, x1) + mag(pen_y, y1) + mag(x1, xe) + mag(y1, ye);
        ax3 = 0;
        ay3 = 0;
        ax2 = pen_x - 2 * x1 + xe;
        ay2 = pen_y - 2 * y1 + ye;
        ax1 = 2 * (x1 - pen_x);
        ay1 = 2 * (y1 - pen_y);
      end else begin
        len = mag(pen_x, x1) + mag(pen_y, y1) + mag(x1, x2) + mag(y1, y2)
            + mag(x2, xe) + mag(y2, ye);
        ax1 = 3 * (x1 - pen_x);
        ay1 = 3 * (y1 - pen_y);
        ax2 = 3 * (x2 - x1) - ax1;
        ay2 = 3 * (y2 - y1) - ay1;
        ax3 = xe - pen_x - ax1 - ax2;
        ay3 = ye - pen_y - ay1 - ay2;
      end
      steps = (len * longint'(scale_q)) >> LEN_SHIFT;
      if (steps < MIN_PTS) steps = MIN_PTS;
      if (steps > STEPS + 1) steps = STEPS + 1;
      for (longint i = 1; i < steps - 1; i++) begin
        t  = (i << FRAC) / (steps - 1);
        t2 = (t * t) >> FRAC;
        t3 = (t2 * t) >> FRAC;
        pt.point_x     = curve_coord(pen_x, ax3, ax2, ax1, t, t2, t3);
        pt.point_y     = curve_coord(pen_y, ay3, ay2, ay1, t, t2, t3);
        pt.last_of_run = 1'b0;
        point_queue.push_back(pt);
      end
    end
    // Start, line and curve all end on the exact end point
    pt.point_x     = req.end_x;
    pt.point_y     = req.end_y;
    pt.last_of_run = 1'b1;
    point_queue.push_back(pt);
    pen_x = xe;
    pen_y = ye;
  endfunction

  // Predict on request, compare on point
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      scale_q      <= PPU_RESET;
      pen_x        = 0;
      pen_y        = 0;
      fail_count_o <= 0;
      points_o     <= 0;
      point_queue.delete();
    end else begin
      if (cfg_we_i) scale_q <= cfg_wdata_i;
      if (in_valid_i && !in_stall_i) flatten_segment(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        points_o <= points_o + 1;
        if (point_queue.size() == 0) begin
          $error("point (%0d, %0d) with nothing expected", out_data_i.point_x,
                 out_data_i.point_y);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = point_queue.pop_front();
          if (out_data_i.point_x !== want.point_x) begin
            $error("point_x expected %0d got %0d", want.point_x, out_data_i.point_x);
            fail_count_o <= fail_count_o + 1;
          end else if (out_data_i.point_y !== want.point_y) begin
            $error("point_y expected %0d got %0d", want.point_y, out_data_i.point_y);
            fail_count_o <= fail_count_o + 1;
          end else if (out_data_i.last_of_run !== want.last_of_run) begin
            $error("last_of_run expected %0b got %0b", want.last_of_run,
                   out_data_i.last_of_run);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = point_queue.size();

endmodule

// ===== verif/bezier_path_flattener_top_test.sv =====
// Top of the Bezier path flattener testbench: clock, reset, segment and scale
// stimulus, output back-pressure, watchdog and verdict. Depends on bpf_pkg,
// bezier_path_flattener_top and bezier_path_flattener_checker.
`timescale 1ns / 1ps

module bezier_path_flattener_top_test;
  import bpf_pkg::*;

  localparam int IDLE_LIMIT = 40000;

  logic             clk_i, rst_ni;
  logic             in_valid_i, in_stall_o;
  in_t              in_data_i;
  logic             out_valid_o, out_stall_i;
  out_t             out_data_o;
  logic             cfg_we_i;
  logic [PPU_W-1:0] cfg_wdata_i;
  int               pending, fails, points, segments, idle_cycles;
  logic             calm;

  bezier_path_flattener_top DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_wdata_i
  );

  bezier_path_flattener_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_wdata_i,
    .pending_o(pending), .fail_count_o(fails), .points_o(points)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Output back-pressure: mostly short stalls, a few long ones
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left  <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                  : $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog on cycles without any accepted request or point
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] near_coord();
    return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
  endfunction

  function automatic in_t make_segment();
    in_t s;
    int  mode;
    mode   = $urandom_range(0, 19);
    s.kind = 2'($urandom_range(0, 3));
    if (mode == 0) begin
      s.ctrl1_x = $urandom();
      s.ctrl1_y = $urandom();
      s.ctrl2_x = $urandom();
      s.ctrl2_y = $urandom();
      s.end_x   = $urandom();
      s.end_y   = $urandom();
    end else if (mode == 1) begin
      s.ctrl1_x = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      s.ctrl1_y = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      s.ctrl2_x = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      s.ctrl2_y = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      s.end_x   = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      s.end_y   = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    end else begin
      s.ctrl1_x = near_coord();
      s.ctrl1_y = near_coord();
      s.ctrl2_x = near_coord();
      s.ctrl2_y = near_coord();
      s.end_x   = near_coord();
      s.end_y   = near_coord();
    end
    return s;
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic send_segment(in_t s);
    int gap;
    gap = calm ? 0 : (($urandom_range(0, 15) == 0) ? $urandom_range(20, 100)
                                                   : $urandom_range(0, 2));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    segments++;
  endtask

  task automatic send_shape(logic [1:0] k, logic [31:0] c1x, logic [31:0] c1y,
                            logic [31:0] c2x, logic [31:0] c2y,
                            logic [31:0] ex, logic [31:0] ey);
    send_segment('{kind: k, ctrl1_x: c1x, ctrl1_y: c1y, ctrl2_x: c2x, ctrl2_y: c2y,
                   end_x: ex, end_y: ey});
  endtask

  // Change the scale once everything in flight has drained
  task automatic set_scale(logic [PPU_W-1:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [PPU_W-1:0] scales[5];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    calm        = 1'b0;
    segments    = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every kind, coordinate extremes, ignored control points
    send_shape(KIND_MOVE, 32'hffffffff, 32'h0, 32'hffffffff, 32'h0, 32'h0, 32'h0);
    send_shape(KIND_LINE, '0, '0, '0, '0, 32'h7fffffff, 32'h80000000);
    send_shape(KIND_MOVE, '0, '0, '0, '0, 32'h80000000, 32'h7fffffff);
    send_shape(KIND_MOVE, '0, '0, '0, '0, 32'h00010000, 32'h00020000);
    send_shape(KIND_QUAD, 32'h00030000, 32'h00050000, 32'hffffffff, 32'hffffffff,
               32'h00060000, 32'h00010000);
    send_shape(KIND_CUBIC, 32'h00100000, 32'hfff00000, 32'h00200000, 32'h00300000,
               32'hffe00000, 32'h00040000);
    send_shape(KIND_QUAD, '0, '0, '0, '0, '0, '0);
    send_shape(KIND_CUBIC, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
               32'h7fffffff, 32'h7fffffff);
    send_shape(KIND_CUBIC, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
               32'h80000000, 32'h80000000);
    send_shape(KIND_QUAD, 32'h7fffffff, 32'h80000000, '0, '0, 32'h80000000,
               32'h7fffffff);
    send_shape(KIND_LINE, '0, '0, '0, '0, 32'h00001234, 32'hffff8000);
    set_scale(16'd0);
    send_shape(KIND_CUBIC, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
               '0, '0);
    send_shape(KIND_QUAD, 32'h40000000, 32'hc0000000, '0, '0, 32'h00050000, '0);
    set_scale(16'hffff);
    send_shape(KIND_QUAD, 32'h00000100, 32'h00000080, '0, '0, 32'h00000200, '0);
    send_shape(KIND_CUBIC, 32'h00000400, '0, 32'h00000400, 32'h00000400, '0,
               32'h00000400);
    set_scale(16'd1);
    send_shape(KIND_CUBIC, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
               32'h7fffffff, 32'h80000000);

    // Random phases over several scale settings
    scales = '{16'd256, 16'd1, 16'hffff, 16'd0, 16'($urandom_range(1, 2047))};
    foreach (scales[p]) begin
      set_scale(scales[p]);
      for (int k = 0; k < 48; k++) begin
        if (k % 16 == 0) calm = ($urandom_range(0, 2) == 0);
        send_segment(make_segment());
      end
      calm = 1'b0;
    end
    in_valid_i <= 1'b0;

    // Drain, then give the block time for anything stray
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d segments over several scale settings, checked %0d points.",
             segments, points);
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
